[sv/rnns_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnns_pkg
// Shared types, codes and the logistic table of the recurrent network step.
// ----------------------------------------------------------------------------
package rnns_pkg;

  // counter width covering up to 256 neurons, parameter pointer width
  localparam int CNT_W = 9;
  localparam int PTR_W = 18;
  localparam int IXW   = 17;

  // activation function codes
  localparam logic [2:0] FN_LOGISTIC  = 3'd1;
  localparam logic [2:0] FN_PLOGISTIC = 3'd2;
  localparam logic [2:0] FN_STEP      = 3'd3;
  localparam logic [2:0] FN_RELU      = 3'd4;
  localparam logic [2:0] FN_TANH      = 3'd5;

  // input transaction actions
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_SENSOR = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_INPUT_COUNT  = 3'd0;
  localparam logic [2:0] REG_HIDDEN_COUNT = 3'd1;
  localparam logic [2:0] REG_OUTPUT_COUNT = 3'd2;
  localparam logic [2:0] REG_BIAS_ENABLE  = 3'd3;
  localparam logic [2:0] REG_HIDDEN_FN    = 3'd4;
  localparam logic [2:0] REG_OUTPUT_FN    = 3'd5;
  localparam logic [2:0] REG_TOPOLOGY     = 3'd6;

  // block kinds of the update plan
  localparam logic [1:0] BK_SKIP = 2'd0;
  localparam logic [1:0] BK_CONN = 2'd1;
  localparam logic [1:0] BK_UPD  = 2'd2;
  localparam logic [1:0] BK_END  = 2'd3;

  // plan steps
  localparam logic [2:0] STEP_IN_HID  = 3'd0;
  localparam logic [2:0] STEP_HID_HID = 3'd1;
  localparam logic [2:0] STEP_HID_UPD = 3'd2;
  localparam logic [2:0] STEP_IN_OUT  = 3'd3;
  localparam logic [2:0] STEP_HID_OUT = 3'd4;
  localparam logic [2:0] STEP_OUT_OUT = 3'd5;
  localparam logic [2:0] STEP_OUT_UPD = 3'd6;
  localparam logic [2:0] STEP_DONE    = 3'd7;

  typedef struct packed {
    logic [CNT_W-1:0] n_in;
    logic [CNT_W-1:0] n_hid;
    logic [CNT_W-1:0] n_out;
    logic [CNT_W-1:0] n_io;
    logic [CNT_W-1:0] n_all;
    logic [2:0]       hfun;
    logic [2:0]       ofun;
  } dims_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [CNT_W-1:0] dst;
    logic [CNT_W-1:0] nd;
    logic [CNT_W-1:0] src;
    logic [CNT_W-1:0] ns;
  } blk_t;

  // 256 * sigma(k/2), k = 0..16
  function automatic logic [8:0] sig_tab(input logic [4:0] k);
    logic [8:0] v;
    unique case (k)
      5'd0:    v = 9'd128;
      5'd1:    v = 9'd159;
      5'd2:    v = 9'd187;
      5'd3:    v = 9'd209;
      5'd4:    v = 9'd225;
      5'd5:    v = 9'd237;
      5'd6:    v = 9'd244;
      5'd7:    v = 9'd248;
      5'd8:    v = 9'd251;
      5'd9:    v = 9'd253;
      5'd10:   v = 9'd254;
      5'd11:   v = 9'd255;
      5'd12:   v = 9'd255;
      default: v = 9'd256;
    endcase
    return v;
  endfunction

endpackage

[sv/recurrent_neural_net_step_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recurrent_neural_net_step_top
// Q8.8 recurrent network step with one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//  channel | direction | signals
//  in_     | input     | action, index, value, last
//  out_    | output    | output_index, activation, final_res
//  cfg_    | input     | index (3b), data (8b)
//
// A final sensor transaction runs an update: a read and a write per neuron for the bias
// pass and per input for the sensor copy, a read, multiply and accumulate per connection
// weight plus a read, wait and write-back per target row, a read, multiply, prepare and
// write per updated neuron and a decode per plan block, all through the one multiplier
// and memory port. Results then leave one at a time, holding while out_ready is low.
// in_ready is low from update start until the last result is taken. Synchronous reset
// clears control state and all activations.
module recurrent_neural_net_step_top #(
  parameter int MAX_NEURONS = 128,
  parameter int MAX_PARAMS  = 4096,
  parameter int MAX_INPUTS  = 32,
  parameter int MAX_OUTPUTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic [11:0]        in_index,
  input  logic signed [15:0] in_value,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_output_index,
  output logic signed [15:0] out_activation,
  output logic               out_final_res,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  import rnns_pkg::*;

  localparam int AW  = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
  localparam int PAW = $clog2(MAX_PARAMS);
  localparam int SW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_INIT_RD = 5'd1;
  localparam logic [4:0] S_INIT_WR = 5'd2;
  localparam logic [4:0] S_COPY_RD = 5'd3;
  localparam logic [4:0] S_COPY_WR = 5'd4;
  localparam logic [4:0] S_BLK     = 5'd5;
  localparam logic [4:0] S_CT_RD   = 5'd6;
  localparam logic [4:0] S_CT_WAIT = 5'd7;
  localparam logic [4:0] S_MAC_RD  = 5'd8;
  localparam logic [4:0] S_MAC_MUL = 5'd9;
  localparam logic [4:0] S_MAC_ACC = 5'd10;
  localparam logic [4:0] S_CT_WR   = 5'd11;
  localparam logic [4:0] S_UP_RD   = 5'd12;
  localparam logic [4:0] S_UP_MUL  = 5'd13;
  localparam logic [4:0] S_UP_PRE  = 5'd14;
  localparam logic [4:0] S_UP_WR   = 5'd15;
  localparam logic [4:0] S_EMIT_RD = 5'd16;
  localparam logic [4:0] S_EMIT_LD = 5'd17;
  localparam logic [4:0] S_EMIT_HD = 5'd18;

  logic [4:0] state_r, state_nxt;

  logic [5:0] cin_r;
  logic [6:0] chid_r;
  logic [4:0] cout_r;
  logic       cbias_r;
  logic [2:0] chfn_r, cofn_r;
  logic [3:0] ctopo_r;

  logic [CNT_W-1:0] t_r, i_r;
  logic [4:0]       k_r;
  logic [2:0]       step_r;
  logic [PTR_W-1:0] pptr_r;
  logic signed [31:0] acc_r, x_r, lx_r;
  logic signed [50:0] prod_r;
  logic [2:0]       code_r;
  logic             take_r, p_oob_r;

  logic               out_valid_r, out_fin_r;
  logic [3:0]         out_idx_r;
  logic signed [15:0] out_act_r;

  // memories and their registered read data
  logic signed [15:0] param_mem [MAX_PARAMS];
  logic signed [15:0] sens_mem  [MAX_INPUTS];
  logic signed [15:0] act_mem   [MAX_NEURONS];
  logic signed [31:0] net_mem   [MAX_NEURONS];
  logic [MAX_NEURONS-1:0] act_vld_r;
  logic signed [15:0] pm_rd_r, sm_rd_r, am_rd_r;
  logic signed [31:0] nm_rd_r;
  logic               am_rv_r;

  dims_t dims;
  blk_t  blk;

  logic             in_acc, is_last_sensor;
  logic [IXW-1:0]   idx_ext;
  logic [CNT_W-1:0] t_inc, i_inc, nidx, aidx;
  logic             t_end, i_end, take_now;
  logic [2:0]       code_nxt;
  logic signed [15:0] pval, aval, act_new;
  logic               am_we;
  logic [CNT_W-1:0]   am_wa;
  logic signed [15:0] am_wd;
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic [32:0]        xneg, wneg;
  logic signed [33:0] sum;
  logic signed [31:0] acc_sat, gsat;
  logic [42:0]        gm;
  logic [31:0]        gneg;

  rnns_plan #(
    .MAX_NEURONS(MAX_NEURONS),
    .MAX_INPUTS (MAX_INPUTS),
    .MAX_OUTPUTS(MAX_OUTPUTS)
  ) u_plan (
    .cin  (cin_r),
    .chid (chid_r),
    .cout (cout_r),
    .chfn (chfn_r),
    .cofn (cofn_r),
    .ctopo(ctopo_r),
    .step (step_r),
    .dims (dims),
    .blk  (blk)
  );

  rnns_actfn u_actfn (
    .code(code_r),
    .net (x_r),
    .lgin(lx_r),
    .act (act_new)
  );

  assign in_ready         = (state_r == S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_output_index = out_idx_r;
  assign out_activation   = out_act_r;
  assign out_final_res    = out_fin_r;

  assign in_acc         = in_valid && in_ready;
  assign is_last_sensor = (in_action == ACT_SENSOR) && in_last;
  assign idx_ext        = IXW'(in_index);

  // sequencer helpers
  always_comb begin
    t_inc    = t_r + 1'b1;
    i_inc    = i_r + 1'b1;
    i_end    = (i_inc == blk.ns);
    nidx     = (state_r == S_INIT_RD || state_r == S_INIT_WR) ? t_r : blk.dst + t_r;
    aidx     = (state_r == S_EMIT_RD) ? dims.n_io + CNT_W'(k_r) : blk.src + i_r;
    code_nxt = (nidx < dims.n_io) ? dims.hfun : dims.ofun;
    unique case (state_r)
      S_INIT_WR: t_end = (t_inc == dims.n_all);
      S_COPY_WR: t_end = (t_inc == dims.n_in);
      default:   t_end = (t_inc == blk.nd);
    endcase
    unique case (state_r)
      S_INIT_RD: take_now = cbias_r && (t_r >= dims.n_in);
      S_MAC_RD:  take_now = 1'b1;
      S_UP_RD:   take_now = (code_nxt == FN_PLOGISTIC);
      default:   take_now = 1'b0;
    endcase
    pval = p_oob_r ? 16'sd0 : pm_rd_r;
    aval = am_rv_r ? am_rd_r : 16'sd0;
  end

  // activation writes: sensor copy and neuron update
  always_comb begin
    am_we = (state_r == S_COPY_WR) || (state_r == S_UP_WR);
    am_wa = (state_r == S_COPY_WR) ? t_r : nidx;
    am_wd = (state_r == S_COPY_WR) ? sm_rd_r : act_new;
  end

  // shared multiplier operands, accumulate and gain saturation
  always_comb begin
    xneg = -{nm_rd_r[31], nm_rd_r};
    wneg = -{{17{pval[15]}}, pval};
    if (state_r == S_UP_MUL) begin
      mul_a = $signed({1'b0, nm_rd_r[31] ? xneg[31:0] : nm_rd_r});
      mul_b = $signed({1'b0, pval[15] ? wneg[16:0] : {1'b0, pval}});
    end else begin
      mul_a = 33'(aval);
      mul_b = 18'(pval);
    end
    sum = 34'(acc_r) + 34'($signed(prod_r[32:0]));
    if (sum > 34'sd2147483647)       acc_sat = 32'sh7fffffff;
    else if (sum < -34'sd2147483648) acc_sat = 32'sh80000000;
    else                             acc_sat = sum[31:0];
    gm   = prod_r[50:8];
    gneg = -gm[31:0];
    if (x_r[31]) gsat = (gm > 43'h80000000) ? 32'sh80000000 : $signed(gneg);
    else         gsat = (gm > 43'h7fffffff) ? 32'sh7fffffff : $signed(gm[31:0]);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_acc && is_last_sensor) state_nxt = S_INIT_RD;
      S_INIT_RD: state_nxt = S_INIT_WR;
      S_INIT_WR: state_nxt = t_end ? S_COPY_RD : S_INIT_RD;
      S_COPY_RD: state_nxt = S_COPY_WR;
      S_COPY_WR: state_nxt = t_end ? S_BLK : S_COPY_RD;
      S_BLK: begin
        unique case (blk.kind)
          BK_CONN: state_nxt = S_CT_RD;
          BK_UPD:  state_nxt = S_UP_RD;
          BK_END:  state_nxt = S_EMIT_RD;
          default: state_nxt = S_BLK;
        endcase
      end
      S_CT_RD:   state_nxt = S_CT_WAIT;
      S_CT_WAIT: state_nxt = S_MAC_RD;
      S_MAC_RD:  state_nxt = S_MAC_MUL;
      S_MAC_MUL: state_nxt = S_MAC_ACC;
      S_MAC_ACC: state_nxt = i_end ? S_CT_WR : S_MAC_RD;
      S_CT_WR:   state_nxt = t_end ? S_BLK : S_CT_RD;
      S_UP_RD:   state_nxt = S_UP_MUL;
      S_UP_MUL:  state_nxt = S_UP_PRE;
      S_UP_PRE:  state_nxt = S_UP_WR;
      S_UP_WR:   state_nxt = t_end ? S_BLK : S_UP_RD;
      S_EMIT_RD: state_nxt = S_EMIT_LD;
      S_EMIT_LD: state_nxt = S_EMIT_HD;
      S_EMIT_HD: if (out_ready) state_nxt = out_fin_r ? S_IDLE : S_EMIT_RD;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cin_r       <= 6'd8;
      chid_r      <= 7'd5;
      cout_r      <= 5'd2;
      cbias_r     <= 1'b0;
      chfn_r      <= 3'd1;
      cofn_r      <= 3'd0;
      ctopo_r     <= 4'd0;
      out_valid_r <= 1'b0;
      act_vld_r   <= '0;
      t_r         <= '0;
      i_r         <= '0;
      k_r         <= '0;
      step_r      <= STEP_IN_HID;
      pptr_r      <= '0;
    end else begin
      state_r <= state_nxt;
      // take configuration writes
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_INPUT_COUNT:  cin_r   <= cfg_data[5:0];
          REG_HIDDEN_COUNT: chid_r  <= cfg_data[6:0];
          REG_OUTPUT_COUNT: cout_r  <= cfg_data[4:0];
          REG_BIAS_ENABLE:  cbias_r <= cfg_data[0];
          REG_HIDDEN_FN:    chfn_r  <= cfg_data[2:0];
          REG_OUTPUT_FN:    cofn_r  <= cfg_data[2:0];
          REG_TOPOLOGY:     ctopo_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      // drop all activations, mark written ones
      if (in_acc && in_action == ACT_CLEAR) act_vld_r <= '0;
      if (am_we) act_vld_r[am_wa[AW-1:0]] <= 1'b1;
      if (take_now) pptr_r <= pptr_r + 1'b1;
      // advance the loop counters
      unique case (state_r)
        S_IDLE: begin
          t_r    <= '0;
          pptr_r <= '0;
        end
        S_INIT_WR, S_COPY_WR, S_CT_WR, S_UP_WR: begin
          t_r <= t_end ? '0 : t_inc;
          if (t_end && state_r != S_INIT_WR && state_r != S_COPY_WR) step_r <= step_r + 1'b1;
          if (t_end && state_r == S_COPY_WR) step_r <= STEP_IN_HID;
        end
        S_BLK: begin
          t_r <= '0;
          i_r <= '0;
          k_r <= '0;
          if (blk.kind == BK_SKIP) step_r <= step_r + 1'b1;
        end
        S_MAC_ACC: i_r <= i_end ? '0 : i_inc;
        S_EMIT_LD: out_valid_r <= 1'b1;
        S_EMIT_HD: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            k_r         <= k_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    p_oob_r <= (pptr_r >= PTR_W'(MAX_PARAMS));
    take_r  <= take_now;
    unique case (state_r)
      S_CT_WAIT: acc_r <= nm_rd_r;
      S_MAC_MUL: prod_r <= mul_a * mul_b;
      S_MAC_ACC: acc_r <= acc_sat;
      S_UP_RD:   code_r <= code_nxt;
      S_UP_MUL: begin
        x_r    <= nm_rd_r;
        prod_r <= mul_a * mul_b;
      end
      S_UP_PRE: begin
        if (code_r == FN_PLOGISTIC) lx_r <= gsat;
        else if (code_r == FN_TANH) lx_r <= {x_r[30:0], 1'b0};
        else                        lx_r <= x_r;
      end
      S_EMIT_LD: begin
        out_act_r <= aval;
        out_idx_r <= k_r[3:0];
        out_fin_r <= ((CNT_W'(k_r) + 1'b1) == dims.n_out);
      end
      default: ;
    endcase
  end

  // parameter store
  always_ff @(posedge clk) begin
    if (in_acc && in_action == ACT_LOAD && idx_ext < IXW'(MAX_PARAMS))
      param_mem[idx_ext[PAW-1:0]] <= in_value;
    pm_rd_r <= param_mem[pptr_r[PAW-1:0]];
  end

  // sensor latch
  always_ff @(posedge clk) begin
    if (in_acc && in_action == ACT_SENSOR && idx_ext < IXW'(MAX_INPUTS))
      sens_mem[idx_ext[SW-1:0]] <= in_value;
    sm_rd_r <= sens_mem[t_r[SW-1:0]];
  end

  // activation store
  always_ff @(posedge clk) begin
    if (am_we) act_mem[am_wa[AW-1:0]] <= am_wd;
    am_rd_r <= act_mem[aidx[AW-1:0]];
    am_rv_r <= act_vld_r[aidx[AW-1:0]];
  end

  // net input store: bias pass and row write-back
  always_ff @(posedge clk) begin
    if (state_r == S_INIT_WR)
      net_mem[nidx[AW-1:0]] <= take_r ? {{8{pval[15]}}, pval, 8'd0} : 32'sd0;
    else if (state_r == S_CT_WR)
      net_mem[nidx[AW-1:0]] <= acc_r;
    nm_rd_r <= net_mem[nidx[AW-1:0]];
  end

  // no new transaction while results are pending
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // final result carries the last output index
  a_final_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_final_res) |-> (CNT_W'(out_output_index) + 1'b1) == dims.n_out)
    else $error("final flag on wrong output index");

  // a taken non-final result is followed by a gap
  a_emit_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_final_res) |=> !out_valid && !in_ready)
    else $error("result sequence broken");

  // a final sensor transaction starts the update
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_action == ACT_SENSOR && in_last) |=> !in_ready)
    else $error("update did not start");

endmodule

[sv/rnns_plan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnns_plan
// Clamps the configured counts and describes each block of the update plan.
// ----------------------------------------------------------------------------
module rnns_plan #(
  parameter int MAX_NEURONS = 128,
  parameter int MAX_INPUTS  = 32,
  parameter int MAX_OUTPUTS = 16
) (
  input  logic [5:0]      cin,
  input  logic [6:0]      chid,
  input  logic [4:0]      cout,
  input  logic [2:0]      chfn,
  input  logic [2:0]      cofn,
  input  logic [3:0]      ctopo,
  input  logic [2:0]      step,
  output rnns_pkg::dims_t dims,
  output rnns_pkg::blk_t  blk
);
  import rnns_pkg::*;

  localparam int MI_I = (MAX_INPUTS < MAX_NEURONS - 1) ? MAX_INPUTS : MAX_NEURONS - 1;
  localparam int OL_I = (MAX_OUTPUTS < 16) ? MAX_OUTPUTS : 16;
  localparam logic [CNT_W-1:0] MI = CNT_W'(MI_I);
  localparam logic [CNT_W-1:0] OL = CNT_W'(OL_I);
  localparam logic [CNT_W-1:0] NMAX = CNT_W'(MAX_NEURONS);
  localparam logic [CNT_W-1:0] HMAX = CNT_W'(64);

  logic [CNT_W-1:0] n_in, room, olim, n_out, hlim, h0, hid, ho;
  logic [2:0]       hfun, ofun;

  // clamp counts and function codes
  always_comb begin
    n_in  = (cin == 6'd0) ? CNT_W'(1) : ((CNT_W'(cin) > MI) ? MI : CNT_W'(cin));
    room  = NMAX - n_in;
    olim  = (room < OL) ? room : OL;
    n_out = (cout == 5'd0) ? CNT_W'(1) : ((CNT_W'(cout) > olim) ? olim : CNT_W'(cout));
    hlim  = room - n_out;
    h0    = (CNT_W'(chid) > HMAX) ? HMAX : CNT_W'(chid);
    hid   = (h0 > hlim) ? hlim : h0;
    ho    = hid + n_out;
    hfun  = (chfn < FN_LOGISTIC || chfn > FN_TANH) ? FN_LOGISTIC : chfn;
    ofun  = (cofn == 3'd0) ? hfun : ((cofn > FN_TANH) ? FN_LOGISTIC : cofn);
  end

  assign dims.n_in  = n_in;
  assign dims.n_hid = hid;
  assign dims.n_out = n_out;
  assign dims.n_io  = n_in + hid;
  assign dims.n_all = n_in + ho;
  assign dims.hfun  = hfun;
  assign dims.ofun  = ofun;

  // describe the current block
  always_comb begin
    blk = '{kind: BK_END, dst: '0, nd: '0, src: '0, ns: '0};
    if (ctopo[0]) begin
      unique case (step)
        STEP_IN_HID:  blk = '{kind: BK_CONN, dst: n_in, nd: ho, src: '0, ns: n_in};
        STEP_HID_HID: blk = '{kind: BK_CONN, dst: n_in, nd: ho, src: n_in, ns: ho};
        STEP_HID_UPD: blk = '{kind: BK_UPD, dst: n_in, nd: ho, src: '0, ns: '0};
        default:      blk = '{kind: BK_END, dst: '0, nd: '0, src: '0, ns: '0};
      endcase
    end else begin
      unique case (step)
        STEP_IN_HID:
          blk = '{kind: (hid != '0) ? BK_CONN : BK_SKIP,
                  dst: n_in, nd: hid, src: '0, ns: n_in};
        STEP_HID_HID:
          blk = '{kind: (ctopo[2] && hid != '0) ? BK_CONN : BK_SKIP,
                  dst: n_in, nd: hid, src: n_in, ns: hid};
        STEP_HID_UPD:
          blk = '{kind: (hid != '0) ? BK_UPD : BK_SKIP,
                  dst: n_in, nd: hid, src: '0, ns: '0};
        STEP_IN_OUT:
          blk = '{kind: (hid == '0 || ctopo[1]) ? BK_CONN : BK_SKIP,
                  dst: n_in + hid, nd: n_out, src: '0, ns: n_in};
        STEP_HID_OUT:
          blk = '{kind: (hid != '0) ? BK_CONN : BK_SKIP,
                  dst: n_in + hid, nd: n_out, src: n_in, ns: hid};
        STEP_OUT_OUT:
          blk = '{kind: ctopo[3] ? BK_CONN : BK_SKIP,
                  dst: n_in + hid, nd: n_out, src: n_in + hid, ns: n_out};
        STEP_OUT_UPD:
          blk = '{kind: BK_UPD, dst: n_in + hid, nd: n_out, src: '0, ns: '0};
        STEP_DONE:
          blk = '{kind: BK_END, dst: '0, nd: '0, src: '0, ns: '0};
      endcase
    end
  end

endmodule

[sv/rnns_actfn.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnns_actfn
// Neuron activation: table logistic with interpolation, step, ReLU, tanh.
// ----------------------------------------------------------------------------
module rnns_actfn (
  input  logic [2:0]         code,
  input  logic signed [31:0] net,
  input  logic signed [31:0] lgin,
  output logic signed [15:0] act
);
  import rnns_pkg::*;

  logic        neg;
  logic [32:0] ngx;
  logic [31:0] mag;
  logic [3:0]  seg;
  logic [8:0]  t0, t1, y;
  logic [4:0]  diff;
  logic [19:0] ip;
  logic signed [15:0] lg;

  // logistic of lgin
  always_comb begin
    neg  = lgin[31];
    ngx  = -{lgin[31], lgin};
    mag  = neg ? ngx[31:0] : lgin;
    seg  = mag[18:15];
    t0   = sig_tab({1'b0, seg});
    t1   = sig_tab(5'({1'b0, seg}) + 5'd1);
    diff = 5'(t1 - t0);
    ip   = diff * mag[14:0];
    y    = (|mag[31:19]) ? 9'd256 : (t0 + 9'(ip[19:15]));
    lg   = neg ? (16'sd256 - $signed({7'd0, y})) : $signed({7'd0, y});
  end

  // select the neuron function
  always_comb begin
    unique case (code)
      FN_STEP: act = net[31] ? 16'sd0 : 16'sd256;
      FN_RELU: begin
        if (net[31])          act = 16'sd0;
        else if (|net[30:23]) act = 16'sd32767;
        else                  act = $signed({1'b0, net[22:8]});
      end
      FN_TANH: begin
        if (net >= 32'sd655360)       act = 16'sd256;
        else if (net <= -32'sd655360) act = -16'sd256;
        else                          act = 16'(lg * 2) - 16'sd256;
      end
      default: act = lg;
    endcase
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for recurrent_neural_net_step_top: loads weights,
// streams sensor transactions through a range of network shapes, topologies
// and activation functions, and compares every emitted output activation
// with a cycle-free Q8.8 predictor of the network update.
// ----------------------------------------------------------------------------
module tb;
  import rnns_pkg::*;

  localparam int NEURON_CAP = 128;
  localparam int PARAM_CAP  = 4096;
  localparam int SENSOR_CAP = 32;
  localparam int OUTPUT_CAP = 16;
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int RANDOM_ITEMS = 150;

  typedef struct {
    logic [3:0]         idx;
    logic signed [15:0] act;
    logic               fin;
  } neuron_out_t;

  // Predicts the output activations of each network update.
  class activation_board;
    int unsigned regs[7];
    int          prm[PARAM_CAP];
    int          sens[SENSOR_CAP];
    int          act[NEURON_CAP];
    int          net[NEURON_CAP];
    int unsigned ptr, ni, nh, no, hf, of;
    int          lut[17] = '{128, 159, 187, 209, 225, 237, 244, 248, 251,
                             253, 254, 255, 255, 256, 256, 256, 256};
    neuron_out_t expected_outs[$];
    int          errors;

    function new();
      regs = '{8, 5, 2, 0, 1, 0, 0};
      foreach (prm[i]) prm[i] = 0;
      foreach (sens[i]) sens[i] = 0;
      foreach (act[i]) act[i] = 0;
      foreach (net[i]) net[i] = 0;
      errors = 0;
      derive();
    endfunction

    function int sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
    endfunction

    function int take_param();
      int v;
      v = (ptr < PARAM_CAP) ? prm[ptr] : 0;
      ptr++;
      return v;
    endfunction

    function int logistic(int x);
      bit          neg;
      longint      m;
      int unsigned seg, frac, diff;
      int          y;
      neg = x < 0;
      m = neg ? -longint'(x) : longint'(x);
      seg = int'(m >> 15);
      if (seg >= 16) begin
        y = 256;
      end else begin
        frac = int'(m & 64'h7fff);
        diff = lut[seg+1] - lut[seg];
        y = lut[seg] + int'((diff * frac) >> 15);
      end
      return neg ? 256 - y : y;
    endfunction

    function int apply_fn(int unsigned code, int x);
      int     w, r;
      longint d, mag, mm;
      case (code)
        FN_PLOGISTIC: begin
          w = take_param();
          d = (w < 0) ? -longint'(w) : longint'(w);
          mag = (x < 0) ? -longint'(x) : longint'(x);
          mm = (mag * d) >> 8;
          return logistic(sat32((x < 0) ? -mm : mm));
        end
        FN_STEP: return (x >= 0) ? 256 : 0;
        FN_RELU: begin
          if (x < 0) return 0;
          r = x >> 8;
          return (r > 32767) ? 32767 : r;
        end
        FN_TANH: begin
          if (x >= (10 << 16)) return 256;
          if (x <= -(10 << 16)) return -256;
          return 2 * logistic(x * 2) - 256;
        end
        default: return logistic(x);
      endcase
    endfunction

    function void connect(int unsigned dst, int unsigned nd, int unsigned src,
                          int unsigned ns);
      int w;
      for (int unsigned t = 0; t < nd; t++)
        for (int unsigned i = 0; i < ns; i++) begin
          w = take_param();
          net[dst+t] = sat32(longint'(net[dst+t]) + longint'(act[src+i]) * longint'(w));
        end
    endfunction

    function void update_range(int unsigned first, int unsigned n);
      for (int unsigned t = first; t < first + n; t++)
        act[t] = apply_fn((t < ni + nh) ? hf : of, net[t]);
    endfunction

    // Clamp the register settings into the network shape actually used.
    function void derive();
      int unsigned room, olim, hid;
      ni = regs[REG_INPUT_COUNT];
      if (ni < 1) ni = 1;
      if (ni > SENSOR_CAP) ni = SENSOR_CAP;
      room = NEURON_CAP - ni;
      olim = (OUTPUT_CAP < 16) ? OUTPUT_CAP : 16;
      if (olim > room) olim = room;
      no = regs[REG_OUTPUT_COUNT];
      if (no < 1) no = 1;
      if (no > olim) no = olim;
      hid = regs[REG_HIDDEN_COUNT];
      if (hid > 64) hid = 64;
      if (hid > room - no) hid = room - no;
      nh = hid;
      hf = regs[REG_HIDDEN_FN];
      if (hf < 1 || hf > 5) hf = FN_LOGISTIC;
      of = regs[REG_OUTPUT_FN];
      if (of == 0) of = hf;
      else if (of > 5) of = FN_LOGISTIC;
    endfunction

    // Number of parameter slots one update reads.
    function int unsigned param_need();
      int unsigned n, topo;
      topo = regs[REG_TOPOLOGY];
      n = regs[REG_BIAS_ENABLE] ? nh + no : 0;
      if (hf == FN_PLOGISTIC) n += nh;
      if (of == FN_PLOGISTIC) n += no;
      if (topo[0]) return n + (nh + no) * ni + (nh + no) * (nh + no);
      n += nh * ni;
      if (topo[2]) n += nh * nh;
      if (nh == 0 || topo[1]) n += no * ni;
      n += no * nh;
      if (topo[3]) n += no * no;
      return n;
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] data);
      int unsigned masks[7] = '{'h3f, 'h7f, 'h1f, 'h1, 'h7, 'h7, 'hf};
      if (idx < 7) regs[idx] = data & masks[idx];
      derive();
    endfunction

    function void run_update();
      int unsigned nn, topo;
      neuron_out_t o;
      derive();
      nn = ni + nh + no;
      topo = regs[REG_TOPOLOGY];
      ptr = 0;
      for (int unsigned t = 0; t < nn; t++)
        net[t] = (regs[REG_BIAS_ENABLE] && t >= ni) ? sat32(longint'(take_param()) * 256) : 0;
      for (int unsigned t = 0; t < ni; t++) act[t] = sens[t];
      if (topo[0]) begin
        connect(ni, nh + no, 0, ni);
        connect(ni, nh + no, ni, nh + no);
        update_range(ni, nh + no);
      end else begin
        if (nh > 0) connect(ni, nh, 0, ni);
        if (topo[2]) connect(ni, nh, ni, nh);
        if (nh > 0) update_range(ni, nh);
        if (nh == 0 || topo[1]) connect(ni + nh, no, 0, ni);
        if (nh > 0) connect(ni + nh, no, ni, nh);
        if (topo[3]) connect(ni + nh, no, ni + nh, no);
        update_range(ni + nh, no);
      end
      for (int unsigned k = 0; k < no; k++) begin
        o.idx = k[3:0];
        o.act = act[ni+nh+k][15:0];
        o.fin = (k + 1 == no);
        expected_outs.push_back(o);
      end
    endfunction

    function void note_input(logic [1:0] action, logic [11:0] index,
                             logic signed [15:0] value, logic last);
      case (action)
        ACT_LOAD:  prm[index] = value;
        ACT_CLEAR: foreach (act[i]) act[i] = 0;
        ACT_SENSOR: begin
          if (index < SENSOR_CAP) sens[index] = value;
          if (last) run_update();
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [3:0] idx, logic signed [15:0] a, logic fin);
      neuron_out_t e;
      if (expected_outs.size() == 0) begin
        $error("unexpected result: output_index %0d activation %0d", idx, a);
        errors++;
        return;
      end
      e = expected_outs.pop_front();
      if (idx !== e.idx) begin
        $error("output_index: expected %0d, got %0d", e.idx, idx);
        errors++;
      end
      if (a !== e.act) begin
        $error("activation: expected %0d, got %0d", e.act, a);
        errors++;
      end
      if (fin !== e.fin) begin
        $error("final_res: expected %0d, got %0d", e.fin, fin);
        errors++;
      end
    endfunction

    function int pending();
      return expected_outs.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_action = ACT_LOAD;
  logic [11:0]        in_index = '0;
  logic signed [15:0] in_value = '0;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [3:0]         out_output_index;
  logic signed [15:0] out_activation;
  logic               out_final_res;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = REG_INPUT_COUNT;
  logic [7:0]         cfg_data = '0;

  activation_board sb = new();
  bit              steady = 1'b0;
  bit              loaded[PARAM_CAP];
  bit              sens_ok[SENSOR_CAP];

  always #2 clk = ~clk;

  recurrent_neural_net_step_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_index         (in_index),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_output_index (out_output_index),
    .out_activation   (out_activation),
    .out_final_res    (out_final_res),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Check each result transaction and, outside steady mode, stall the result side at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_output_index, out_activation, out_final_res);
    out_ready <= steady || ($urandom_range(99) >= 35);
  end

  // Hold a transaction until accepted, outside steady mode at times with a random gap ahead of it.
  task automatic send(logic [1:0] action, logic [11:0] index,
                      logic signed [15:0] value, logic last);
    if (!steady && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= action;
    in_index  <= index;
    in_value  <= value;
    in_last   <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_input(action, index, value, last);
    if (action == ACT_LOAD) loaded[index] = 1'b1;
    if (action == ACT_SENSOR && index < SENSOR_CAP) sens_ok[index] = 1'b1;
  endtask

  // Stop sending and wait for every expected result.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_weight();
    if ($urandom_range(3) == 0) return 16'($urandom_range(16'hffff));
    return 16'(int'($urandom_range(1023)) - 512);
  endfunction

  task automatic set_config(int unsigned v[7]);
    drain();
    repeat (20) @(posedge clk);
    for (int i = 0; i < 7; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data  <= v[i][7:0];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(i[2:0], v[i][7:0]);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Load every weight slot and sensor the next update will read.
  task automatic fill_needed();
    int unsigned need;
    need = sb.param_need();
    for (int i = 0; i < need && i < PARAM_CAP; i++)
      if (!loaded[i]) send(ACT_LOAD, i[11:0], rand_weight(), 1'b0);
    for (int i = 0; i < sb.ni; i++)
      if (!sens_ok[i]) send(ACT_SENSOR, i[11:0], rand_weight(), 1'b0);
  endtask

  task automatic update(logic [11:0] index, logic signed [15:0] value);
    fill_needed();
    send(ACT_SENSOR, index, value, 1'b1);
  endtask

  initial begin
    int unsigned shapes[9][7] = '{
      '{8, 5, 2, 0, 1, 0, 0},
      '{1, 0, 1, 1, 2, 0, 2},
      '{4, 3, 3, 1, 3, 4, 4},
      '{6, 4, 4, 1, 5, 2, 8},
      '{3, 2, 2, 0, 4, 5, 1},
      '{0, 127, 1, 0, 7, 6, 0},
      '{2, 0, 31, 1, 2, 2, 6},
      '{63, 0, 0, 0, 0, 7, 3},
      '{5, 1, 4, 1, 4, 3, 10}
    };
    int unsigned v[7];
    int          sent, phase_items, limit, r;
    logic [11:0] idx;

    foreach (loaded[i]) loaded[i] = 1'b0;
    foreach (sens_ok[i]) sens_ok[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset shape, field extremes and ignored actions.
    set_config(shapes[0]);
    send(ACT_LOAD, 12'd0, -16'sd32768, 1'b0);
    send(ACT_LOAD, 12'd4095, 16'sd32767, 1'b0);
    send(ACT_NONE, 12'hfff, 16'sh7fff, 1'b1);
    send(ACT_LOAD, 12'd5, 16'sd100, 1'b1);
    send(ACT_CLEAR, 12'd0, 16'sd0, 1'b1);
    send(ACT_SENSOR, 12'd4095, 16'sh7fff, 1'b0);
    send(ACT_SENSOR, 12'd0, -16'sd32768, 1'b0);
    update(12'd7, 16'sd32767);
    send(ACT_CLEAR, 12'd0, 16'sd0, 1'b0);
    update(12'd31, 16'sd1);
    update(12'd4095, 16'sd0);

    // Random: a run of phases, each with its own network shape.
    sent = 0;
    for (int p = 1; sent < RANDOM_ITEMS; p++) begin
      if (p < 9) begin
        v = shapes[p];
      end else begin
        v = '{$urandom_range(1, 4), $urandom_range(0, 3), $urandom_range(1, 4),
              $urandom_range(1), $urandom_range(7), $urandom_range(7),
              $urandom_range(15)};
      end
      set_config(v);
      limit = (sb.ni + sb.nh > 40) ? 8 : 16;
      for (phase_items = 0; phase_items < limit && sent < RANDOM_ITEMS; phase_items++) begin
        steady = (sent >= 70 && sent < 120);
        if (sent == 50) drain();
        r = $urandom_range(99);
        idx = 12'($urandom_range(sb.ni - 1));
        if (r < 50) begin
          send(ACT_SENSOR, idx, rand_weight(), 1'b0);
        end else if (r < 62) begin
          if ($urandom_range(1)) idx = 12'($urandom_range(4095));
          else idx = 12'($urandom_range(sb.param_need() > 0 && sb.param_need() <= PARAM_CAP ?
                                        sb.param_need() - 1 : PARAM_CAP - 1));
          send(ACT_LOAD, idx, rand_weight(), 1'b0);
        end else if (r < 66) begin
          send(ACT_CLEAR, 12'($urandom_range(4095)), 16'($urandom_range(16'hffff)),
               1'($urandom_range(1)));
        end else if (r < 69) begin
          send(ACT_NONE, 12'($urandom_range(4095)), 16'($urandom_range(16'hffff)),
               1'($urandom_range(1)));
        end else if (r < 72) begin
          send(ACT_LOAD, 12'($urandom_range(4095)), rand_weight(), 1'b1);
        end else if (r < 75) begin
          update(12'($urandom_range(SENSOR_CAP, 4095)), 16'($urandom_range(16'hffff)));
        end else begin
          update(idx, rand_weight());
        end
        sent++;
      end
    end
    steady = 1'b0;

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** recurrent_neural_net_step_top: PASSED **");
    end else begin
      $display("** recurrent_neural_net_step_top: FAILED **");
    end
    $finish;
  end

  // Bound the run in case the block hangs.
  initial begin
    #20_000_000;
    $display("** recurrent_neural_net_step_top: FAILED **");
    $finish;
  end

endmodule
